>>> rtl/core/accumulator_stack_machine_macros.svh
// assertion macros shared by the checker
`ifndef ACCUMULATOR_STACK_MACHINE_MACROS_SVH
`define ACCUMULATOR_STACK_MACHINE_MACROS_SVH

// same-cycle implication, off during reset
`define ASM_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/asm_pkg.sv
`default_nettype none

package asm_pkg;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 6;

  // instruction kinds
  localparam logic [KIND_W-1:0] K_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] K_POP  = 3'd1;
  localparam logic [KIND_W-1:0] K_ADD  = 3'd2;
  localparam logic [KIND_W-1:0] K_SUB  = 3'd3;
  localparam logic [KIND_W-1:0] K_CMP  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // compare results pushed back on the stack
  localparam logic [DATA_W-1:0] CMP_LESS    = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] CMP_EQUAL   = 32'h0000_0000;
  localparam logic [DATA_W-1:0] CMP_GREATER = 32'h0000_0001;

  typedef struct packed {
    logic [DATA_W-1:0]   acc;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   cmp_word;
  } alu_out_t;

endpackage

`default_nettype wire

>>> rtl/core/asm_stack_ram.sv
`default_nettype none

module asm_stack_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [asm_pkg::DATA_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [asm_pkg::DATA_W-1:0] rdata
);

  logic [asm_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/asm_alu.sv
`default_nettype none

module asm_alu (
  input  wire logic [asm_pkg::KIND_W-1:0] kind,
  input  wire logic [asm_pkg::DATA_W-1:0] acc,
  input  wire logic [asm_pkg::DATA_W-1:0] pop_value,
  input  wire logic                       stack_empty,
  input  wire logic                       stack_full,
  output asm_pkg::alu_out_t               res
);

  always_comb begin
    res.acc    = acc;
    res.status = asm_pkg::ST_OK;
    if ($signed(pop_value) < $signed(acc)) begin
      res.cmp_word = asm_pkg::CMP_LESS;
    end else if (pop_value == acc) begin
      res.cmp_word = asm_pkg::CMP_EQUAL;
    end else begin
      res.cmp_word = asm_pkg::CMP_GREATER;
    end
    unique case (kind)
      asm_pkg::K_PUSH: begin
        if (stack_full) res.status = asm_pkg::ST_OVERFLOW;
      end
      asm_pkg::K_POP: begin
        res.acc = pop_value;
        if (stack_empty) res.status = asm_pkg::ST_UNDERFLOW;
      end
      asm_pkg::K_ADD: begin
        res.acc = acc + pop_value;
        if (stack_empty) res.status = asm_pkg::ST_UNDERFLOW;
      end
      asm_pkg::K_SUB: begin
        res.acc = acc - pop_value;
        if (stack_empty) res.status = asm_pkg::ST_UNDERFLOW;
      end
      asm_pkg::K_CMP: begin
        if (stack_empty) res.status = asm_pkg::ST_UNDERFLOW;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/accumulator_stack_machine.sv
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tuser kind, s_tdata operand
// m       | out | m_tvalid/m_tready  | m_tuser status, m_tdata acc_value + depth
//
// each item is accepted (stack top read issued to the memory unless the stack is empty),
// then executed once the registered read data is back
// rst is synchronous: accumulator and stack count go to zero, memory is not cleared
// an item may be accepted while the last result still waits on m_tready;
// execute then holds until the output register is free
`default_nettype none

module accumulator_stack_machine #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] operand
  input  wire logic [2:0]  s_tuser,   // [2:0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [31:0] acc_value, [37:32] depth, [39:38] zero
  output logic      [1:0]  m_tuser    // [1:0] status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = asm_pkg::DEPTH_W;
  localparam int XW = asm_pkg::DATA_W;

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  // architectural state
  logic [XW-1:0] acc;
  logic [CW-1:0] count;

  // item under execution
  logic [asm_pkg::KIND_W-1:0] cur_kind;
  logic [XW-1:0]              cur_operand;

  logic s_accept;
  logic done;
  logic stack_empty;
  logic stack_full;
  logic [AW-1:0] top_addr;

  logic [XW-1:0] rdata;
  logic [XW-1:0] pop_value;

  logic          we;
  logic [AW-1:0] waddr;
  logic [XW-1:0] wdata;
  logic [CW-1:0] count_next;

  asm_pkg::alu_out_t alu_res;

  assign s_tready = (state == IDLE);
  assign s_accept = s_tvalid && s_tready;
  // execute completes when the output register can take the result
  assign done     = (state == EXEC) && (!m_tvalid || m_tready);

  assign stack_empty = (count == '0);
  assign stack_full  = (count >= CW'(STACK_DEPTH));
  assign top_addr    = AW'(count - CW'(1));

  // an empty stack pops as zero
  assign pop_value = stack_empty ? '0 : rdata;

  asm_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (s_accept && !stack_empty),
    .raddr (top_addr),
    .rdata (rdata)
  );

  asm_alu u_alu (
    .kind        (cur_kind),
    .acc         (acc),
    .pop_value   (pop_value),
    .stack_empty (stack_empty),
    .stack_full  (stack_full),
    .res         (alu_res)
  );

  // stack write-back and new count
  always_comb begin
    we         = 1'b0;
    waddr      = AW'(count);
    wdata      = cur_operand;
    count_next = count;
    unique case (cur_kind)
      asm_pkg::K_PUSH: begin
        if (!stack_full) begin
          we         = done;
          count_next = count + CW'(1);
        end
      end
      asm_pkg::K_POP, asm_pkg::K_ADD, asm_pkg::K_SUB: begin
        if (!stack_empty) count_next = count - CW'(1);
      end
      asm_pkg::K_CMP: begin
        // pop then push lands on the same slot; empty stack grows to one
        we    = done;
        wdata = alu_res.cmp_word;
        if (stack_empty) begin
          waddr      = '0;
          count_next = CW'(1);
        end else begin
          waddr = top_addr;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      acc      <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (s_accept) state <= EXEC;
        end
        EXEC: begin
          if (done) begin
            state    <= IDLE;
            acc      <= alu_res.acc;
            count    <= count_next;
            m_tvalid <= 1'b1;
          end
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      cur_kind    <= s_tuser;
      cur_operand <= s_tdata;
    end
    if (done) begin
      m_tdata <= {2'b00, DW'(count_next), alu_res.acc};
      m_tuser <= alu_res.status;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/asm_checker.sv
`default_nettype none
`include "accumulator_stack_machine_macros.svh"

module asm_checker #(
  parameter int STACK_DEPTH = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  localparam logic [5:0] FULL_DEPTH = 6'(STACK_DEPTH);

  // one item in flight: no second accept right after one
  `ASM_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // a result is on the output after an accept, once EXEC has registered it
  `ASM_ASSERT(a_result_follows, s_tvalid && s_tready, ##2 m_tvalid)

  // underflow leaves the stack empty, or holding one compare result
  `ASM_ASSERT(a_underflow_depth, m_tvalid && m_tuser == asm_pkg::ST_UNDERFLOW, m_tdata[37:32] == 6'd0 || m_tdata[37:32] == 6'd1)

  // overflow only ever reported on a full stack
  `ASM_ASSERT(a_overflow_depth, m_tvalid && m_tuser == asm_pkg::ST_OVERFLOW, m_tdata[37:32] == FULL_DEPTH)

  // status code three is never produced
  `ASM_ASSERT(a_status_range, m_tvalid, m_tuser != 2'd3)

endmodule

bind accumulator_stack_machine asm_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_asm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
